FILE: design/power_source_transfer_switch_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the power source transfer switch
// Concurrent check macros that compile to nothing in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef POWER_SOURCE_TRANSFER_SWITCH_CORE_ASSERT_SVH
`define POWER_SOURCE_TRANSFER_SWITCH_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define PSTC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("power source transfer switch check failed");

// The consequent must hold in the cycle after the antecedent.
`define PSTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("power source transfer switch check failed");

`else

`define PSTC_ASSERT_SAME(label, clk, rst, ante, cons)
`define PSTC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: design/pst_pkg.sv
// ---------------------------------------------------------------------------
// Power source transfer switch package
// Shared widths, source codes, gate patterns, register indexes and types.
// ---------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

   localparam int unsigned MV_W        = 16;
   localparam int unsigned VIOL_W      = 8;
   localparam int unsigned TICK_W      = 16;
   localparam int unsigned GATE_W      = 4;
   localparam int unsigned SRC_W       = 2;
   localparam int unsigned CSR_ADDR_W  = 2;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned REQ_TDATA_W = 32;
   localparam int unsigned RSP_TDATA_W = 40;

   typedef logic [SRC_W-1:0] src_type;

   localparam src_type SRC_NONE    = 2'd0;
   localparam src_type SRC_MAIN    = 2'd1;
   localparam src_type SRC_RESERVE = 2'd2;

   // Gate bits: bit0 main high, bit1 reserve high, bit2 reserve low, bit3 main low.
   localparam logic [GATE_W-1:0] GATES_OFF     = 4'b0000;
   localparam logic [GATE_W-1:0] GATES_MAIN    = 4'b1001;
   localparam logic [GATE_W-1:0] GATES_RESERVE = 4'b0110;

   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_VIOL_LIMIT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEAD_TIME  = 2'd2;

   localparam logic [MV_W-1:0]   THRESHOLD_RST  = 16'd10000;
   localparam logic [VIOL_W-1:0] VIOL_LIMIT_RST = 8'd3;
   localparam logic [TICK_W-1:0] DEAD_TIME_RST  = 16'd1000;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'b01,
      MODE_DEAD = 2'b10
   } mode_type;

   typedef struct packed {
      logic [MV_W-1:0]   threshold_mv;
      logic [VIOL_W-1:0] violation_limit;
      logic [TICK_W-1:0] dead_time_ticks;
   } cfg_type;

   typedef struct packed {
      logic            tick;
      logic [MV_W-1:0] main_mv;
      logic [MV_W-1:0] reserve_mv;
   } item_type;

   typedef struct packed {
      src_type           active_source;
      src_type           target_source;
      logic              switching;
      logic [GATE_W-1:0] gate_drive;
      logic [VIOL_W-1:0] violations;
      logic [MV_W-1:0]   active_voltage_mv;
      logic              switch_started;
   } result_type;

endpackage

`default_nettype wire

FILE: design/pst_csr.sv
// ---------------------------------------------------------------------------
// Configuration registers
// Holds the threshold, violation limit and dead time written over the CSR port.
// ---------------------------------------------------------------------------
`default_nettype none

module pst_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [pst_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [pst_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output      pst_pkg::cfg_type                  cfg
);

   pst_pkg::cfg_type cfg_ff;
   pst_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            pst_pkg::CSR_THRESHOLD:  cfg_in.threshold_mv    = csr_wdata;
            pst_pkg::CSR_VIOL_LIMIT: cfg_in.violation_limit = csr_wdata[pst_pkg::VIOL_W-1:0];
            pst_pkg::CSR_DEAD_TIME:  cfg_in.dead_time_ticks = csr_wdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_mv    <= pst_pkg::THRESHOLD_RST;
         cfg_ff.violation_limit <= pst_pkg::VIOL_LIMIT_RST;
         cfg_ff.dead_time_ticks <= pst_pkg::DEAD_TIME_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: design/pst_in_reg.sv
// ---------------------------------------------------------------------------
// Request input register
// Captures one request per cycle and holds it until the engine takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module pst_in_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output      logic              req_tready,
   input  wire pst_pkg::item_type req_item,
   input  wire logic              advance,
   output      logic              item_valid,
   output      pst_pkg::item_type item
);

   logic              valid_ff;
   logic              valid_in;
   pst_pkg::item_type item_ff;

   // The register may load when it is empty or its content moves on this cycle.
   assign req_tready = !valid_ff || advance;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

FILE: design/pst_engine.sv
// ---------------------------------------------------------------------------
// Transfer switch engine
// Holds the switch state, applies one request per cycle while results drain and registers the result.
// ---------------------------------------------------------------------------
`default_nettype none

`include "power_source_transfer_switch_core_assert.svh"

module pst_engine (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire pst_pkg::cfg_type    cfg,
   input  wire logic                item_valid,
   input  wire pst_pkg::item_type   item,
   output      logic                advance,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      pst_pkg::result_type rsp
);

   pst_pkg::mode_type                mode_ff, mode_in;
   pst_pkg::src_type                 cur_ff, cur_in;
   pst_pkg::src_type                 pend_ff, pend_in;
   logic [pst_pkg::VIOL_W-1:0]       viol_ff, viol_in;
   logic [pst_pkg::TICK_W-1:0]       dtc_ff, dtc_in;
   logic [pst_pkg::GATE_W-1:0]       gate_ff, gate_in;
   logic [pst_pkg::MV_W-1:0]         main_mv_ff, main_mv_in;
   logic [pst_pkg::MV_W-1:0]         res_mv_ff, res_mv_in;
   logic                             rsp_valid_ff;
   pst_pkg::result_type              rsp_ff, rsp_in;

   logic                             consume;
   logic                             main_ok;
   logic                             res_ok;
   logic [pst_pkg::VIOL_W-1:0]       viol_inc;
   logic                             hit;
   logic [pst_pkg::TICK_W-1:0]       dtc_inc;
   logic                             start;
   pst_pkg::src_type                 start_target;
   logic [pst_pkg::MV_W-1:0]         act_mv;
   logic [pst_pkg::VIOL_W-1:0]       viol_sel;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign consume = item_valid && advance;

   assign main_ok  = item.main_mv >= cfg.threshold_mv;
   assign res_ok   = item.reserve_mv >= cfg.threshold_mv;
   assign viol_inc = (viol_ff == '1) ? viol_ff : viol_ff + 1'b1;
   assign hit      = viol_inc >= cfg.violation_limit;
   assign dtc_inc  = (dtc_ff == '1) ? dtc_ff : dtc_ff + 1'b1;

   // Decide counting and switch start for a sample taken while idle.
   always_comb begin
      viol_in      = viol_ff;
      start        = 1'b0;
      start_target = pst_pkg::SRC_NONE;
      if (!main_ok && !res_ok) begin
         viol_in      = viol_inc;
         start        = hit;
         start_target = pst_pkg::SRC_NONE;
      end else begin
         unique case (cur_ff)
            pst_pkg::SRC_MAIN: begin
               if (!main_ok) begin
                  viol_in      = viol_inc;
                  start        = hit && res_ok;
                  start_target = pst_pkg::SRC_RESERVE;
               end else begin
                  viol_in = '0;
               end
            end
            pst_pkg::SRC_RESERVE: begin
               priority if (main_ok) begin
                  viol_in      = viol_inc;
                  start        = hit;
                  start_target = pst_pkg::SRC_MAIN;
               end else if (!res_ok) begin
                  viol_in      = viol_inc;
                  start        = hit;
                  start_target = pst_pkg::SRC_NONE;
               end else begin
                  viol_in = '0;
               end
            end
            default: begin
               // No source connected: a good main wins over a good reserve.
               if (main_ok) begin
                  viol_in      = viol_inc;
                  start        = hit;
                  start_target = pst_pkg::SRC_MAIN;
               end else begin
                  viol_in      = viol_inc;
                  start        = hit;
                  start_target = pst_pkg::SRC_RESERVE;
               end
            end
         endcase
      end
   end

   // Next state for the request in the input register.
   always_comb begin
      mode_in    = mode_ff;
      cur_in     = cur_ff;
      pend_in    = pend_ff;
      dtc_in     = dtc_ff;
      gate_in    = gate_ff;
      main_mv_in = main_mv_ff;
      res_mv_in  = res_mv_ff;
      rsp_in     = rsp_ff;
      if (item.tick) begin
         if (mode_ff == pst_pkg::MODE_DEAD) begin
            dtc_in = dtc_inc;
            if (dtc_inc >= cfg.dead_time_ticks) begin
               unique case (pend_ff)
                  pst_pkg::SRC_MAIN:    gate_in = pst_pkg::GATES_MAIN;
                  pst_pkg::SRC_RESERVE: gate_in = pst_pkg::GATES_RESERVE;
                  default:              gate_in = pst_pkg::GATES_OFF;
               endcase
               cur_in  = pend_ff;
               mode_in = pst_pkg::MODE_IDLE;
               dtc_in  = '0;
            end
         end
      end else if (mode_ff == pst_pkg::MODE_IDLE) begin
         main_mv_in = item.main_mv;
         res_mv_in  = item.reserve_mv;
         if (start) begin
            pend_in = start_target;
            mode_in = pst_pkg::MODE_DEAD;
            gate_in = pst_pkg::GATES_OFF;
            dtc_in  = '0;
         end
      end

      unique case (cur_in)
         pst_pkg::SRC_MAIN:    act_mv = main_mv_in;
         pst_pkg::SRC_RESERVE: act_mv = res_mv_in;
         default:              act_mv = '0;
      endcase

      rsp_in.active_source     = cur_in;
      rsp_in.target_source     = pend_in;
      rsp_in.switching         = (mode_in == pst_pkg::MODE_DEAD);
      rsp_in.gate_drive        = gate_in;
      rsp_in.violations        = viol_sel;
      rsp_in.active_voltage_mv = act_mv;
      rsp_in.switch_started    = !item.tick && (mode_ff == pst_pkg::MODE_IDLE) && start;
   end

   // The violation count moves only on idle samples and clears when a switch completes.
   always_comb begin
      priority if (item.tick) begin
         viol_sel = ((mode_ff == pst_pkg::MODE_DEAD) && (dtc_inc >= cfg.dead_time_ticks))
                    ? '0 : viol_ff;
      end else if (mode_ff == pst_pkg::MODE_IDLE) begin
         viol_sel = viol_in;
      end else begin
         viol_sel = viol_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= pst_pkg::MODE_DEAD;
         cur_ff     <= pst_pkg::SRC_NONE;
         pend_ff    <= pst_pkg::SRC_NONE;
         viol_ff    <= '0;
         dtc_ff     <= '0;
         gate_ff    <= pst_pkg::GATES_OFF;
         main_mv_ff <= '0;
         res_mv_ff  <= '0;
      end else if (consume) begin
         mode_ff    <= mode_in;
         cur_ff     <= cur_in;
         pend_ff    <= pend_in;
         viol_ff    <= viol_sel;
         dtc_ff     <= dtc_in;
         gate_ff    <= gate_in;
         main_mv_ff <= main_mv_in;
         res_mv_ff  <= res_mv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (consume) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // The main and reserve gate pairs are never driven at the same time.
   `PSTC_ASSERT_SAME(a_no_shoot_through, clock, reset, 1'b1, !((gate_ff[0] || gate_ff[3]) && (gate_ff[1] || gate_ff[2])))
   // All gates stay off while the dead time runs.
   `PSTC_ASSERT_SAME(a_dead_gates_off, clock, reset, mode_ff == pst_pkg::MODE_DEAD, gate_ff == pst_pkg::GATES_OFF)
   // A switch that starts leaves the engine in dead time with a cleared tick count.
   `PSTC_ASSERT_NEXT(a_start_enters_dead, clock, reset, consume && rsp_in.switch_started, (mode_ff == pst_pkg::MODE_DEAD) && (dtc_ff == '0))
   // A delivered result that reports a new switch also reports the dead time.
   `PSTC_ASSERT_SAME(a_started_switching, clock, reset, rsp_valid_ff && rsp_ff.switch_started, rsp_ff.switching && (rsp_ff.gate_drive == pst_pkg::GATES_OFF))

endmodule

`default_nettype wire

FILE: design/power_source_transfer_switch_core.sv
// ---------------------------------------------------------------------------
// Power source transfer switch core
// Break-before-make selection between a main and a reserve supply.
// ---------------------------------------------------------------------------
// Each request is either a voltage sample (tuser low) or one microsecond tick
// (tuser high), and each request produces exactly one response that reports
// the switch state after that request. The block takes one request per clock
// cycle for as long as responses are drained: a request is captured in an
// input register, evaluated by the engine against the switch state and
// written to the response register, from which its response is presented.
// The rate is set by the single state update in the engine. After reset
// the block is in the dead time of a switch to no source, with all gates off,
// so ticks are needed before any source can be connected. Configuration
// registers are written through the CSR port: index 0 is the good-voltage
// threshold in millivolts, index 1 the number of consecutive violating samples
// before a switch, and index 2 the dead time in ticks; other indexes are
// ignored. Write them only while no request is in flight.
`default_nettype none

module power_source_transfer_switch_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request stream.
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic [pst_pkg::REQ_TDATA_W-1:0]   req_tdata,  // main_mv[15:0], reserve_mv[31:16]
   input  wire logic [0:0]                        req_tuser,  // func[0]
   // Response stream.
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // active_source[1:0], target_source[3:2], switching[4], gate_drive[8:5],
   // violations[16:9], active_voltage_mv[32:17], switch_started[33], zero[39:34]
   output      logic [pst_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // Configuration write port.
   input  wire logic                              csr_we,
   input  wire logic [pst_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [pst_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   pst_pkg::cfg_type    cfg;
   pst_pkg::item_type   req_item;
   pst_pkg::item_type   item;
   logic                item_valid;
   logic                advance;
   pst_pkg::result_type rsp;

   assign req_item.tick       = req_tuser[0];
   assign req_item.main_mv    = req_tdata[15:0];
   assign req_item.reserve_mv = req_tdata[31:16];

   pst_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pst_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   pst_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   // Pack the response fields, first field in the lowest bits.
   assign rsp_tdata = {6'b000000,
                       rsp.switch_started,
                       rsp.active_voltage_mv,
                       rsp.violations,
                       rsp.gate_drive,
                       rsp.switching,
                       rsp.target_source,
                       rsp.active_source};

endmodule

`default_nettype wire

FILE: bench/tb.sv
// ---------------------------------------------------------------------------
// Transfer switch core testbench
// Streams voltage samples and microsecond ticks into the transfer switch
// core, predicts every response with a behavioral copy of the switch, and
// compares each field while both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module tb;

   // Index 3 is not decoded by the block; writes to it must have no effect.
   localparam logic [pst_pkg::CSR_ADDR_W-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 1000000;

   // Clock and the single reset at the start of the run.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #6 clock = ~clock;

   // Every block input starts at a known value.
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [pst_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [0:0]                      req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [pst_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            csr_we     = 1'b0;
   logic [pst_pkg::CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [pst_pkg::CSR_DATA_W-1:0]  csr_wdata  = '0;

   power_source_transfer_switch_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Requests waiting to be driven, and the responses the switch must give.
   pst_pkg::item_type   request_q[$];
   pst_pkg::result_type switch_expect_q[$];

   // Idling mix of the current phase, in percent of cycles.
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   int unsigned mismatches        = 0;
   int unsigned requests_seen     = 0;
   int unsigned responses_checked = 0;
   int unsigned switches_started  = 0;
   int unsigned switches_done     = 0;
   int unsigned cycle_count       = 0;

   // Behavioral copy of the switch: its configuration and its state.
   logic [pst_pkg::MV_W-1:0]   cfg_threshold_mv;
   logic [pst_pkg::VIOL_W-1:0] cfg_violation_limit;
   logic [pst_pkg::TICK_W-1:0] cfg_dead_time;

   pst_pkg::src_type           sw_active;
   pst_pkg::src_type           sw_target;
   logic                       sw_in_dead;
   logic [pst_pkg::VIOL_W-1:0] sw_viol;
   logic [pst_pkg::TICK_W-1:0] sw_dead_cnt;
   logic [pst_pkg::GATE_W-1:0] sw_gates;
   logic [pst_pkg::MV_W-1:0]   sw_last_main;
   logic [pst_pkg::MV_W-1:0]   sw_last_reserve;

   // One more consecutive violation, saturating. A limit of zero is reached
   // by every counted violation, since the count is never below zero.
   function automatic logic bump_violations();
      if (sw_viol != 8'hFF) begin
         sw_viol = sw_viol + 8'd1;
      end
      return sw_viol >= cfg_violation_limit;
   endfunction

   // Applies one request to the switch copy and returns the response it owes.
   function automatic pst_pkg::result_type advance_switch(
         input logic tick,
         input logic [pst_pkg::MV_W-1:0] main_mv,
         input logic [pst_pkg::MV_W-1:0] reserve_mv);
      pst_pkg::result_type rsp;
      logic                main_ok;
      logic                res_ok;
      logic                start_req;
      pst_pkg::src_type    goal;

      start_req = 1'b0;
      goal      = pst_pkg::SRC_NONE;
      if (!tick) begin
         // Samples that arrive during the dead time are dropped entirely.
         if (!sw_in_dead) begin
            sw_last_main    = main_mv;
            sw_last_reserve = reserve_mv;
            main_ok = main_mv >= cfg_threshold_mv;
            res_ok  = reserve_mv >= cfg_threshold_mv;
            if (!main_ok && !res_ok) begin
               // Both supplies bad: head for no source, even if none is active.
               start_req = bump_violations();
               goal      = pst_pkg::SRC_NONE;
            end else if (sw_active == pst_pkg::SRC_MAIN) begin
               if (!main_ok) begin
                  start_req = bump_violations() && res_ok;
                  goal      = pst_pkg::SRC_RESERVE;
               end else begin
                  sw_viol = '0;
               end
            end else if (sw_active == pst_pkg::SRC_RESERVE) begin
               // Main is preferred, so a good main counts against reserve.
               // Reserve bad with main bad was taken by the first branch.
               if (main_ok) begin
                  start_req = bump_violations();
                  goal      = pst_pkg::SRC_MAIN;
               end else begin
                  sw_viol = '0;
               end
            end else if (main_ok) begin
               start_req = bump_violations();
               goal      = pst_pkg::SRC_MAIN;
            end else begin
               start_req = bump_violations();
               goal      = pst_pkg::SRC_RESERVE;
            end
            if (start_req) begin
               // Break before make: all gates open as the dead time starts.
               sw_target   = goal;
               sw_in_dead  = 1'b1;
               sw_gates    = pst_pkg::GATES_OFF;
               sw_dead_cnt = '0;
               switches_started++;
            end
         end
      end else if (sw_in_dead) begin
         if (sw_dead_cnt != 16'hFFFF) begin
            sw_dead_cnt = sw_dead_cnt + 16'd1;
         end
         if (sw_dead_cnt >= cfg_dead_time) begin
            sw_gates    = (sw_target == pst_pkg::SRC_MAIN)    ? pst_pkg::GATES_MAIN :
                          (sw_target == pst_pkg::SRC_RESERVE) ? pst_pkg::GATES_RESERVE :
                                                                pst_pkg::GATES_OFF;
            sw_active   = sw_target;
            sw_in_dead  = 1'b0;
            sw_viol     = '0;
            sw_dead_cnt = '0;
            switches_done++;
         end
      end

      rsp.active_source     = sw_active;
      rsp.target_source     = sw_target;
      rsp.switching         = sw_in_dead;
      rsp.gate_drive        = sw_gates;
      rsp.violations        = sw_viol;
      rsp.active_voltage_mv = (sw_active == pst_pkg::SRC_MAIN)    ? sw_last_main :
                              (sw_active == pst_pkg::SRC_RESERVE) ? sw_last_reserve : '0;
      rsp.switch_started    = start_req;
      return rsp;
   endfunction

   task automatic check_field(input string fname, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("Mismatch on response %0d, %s: expected 0x%0h, got 0x%0h",
                     responses_checked, fname, want, got);
         end
      end
   endtask

   // Request driver: presents the next queued request whenever the slot is
   // free, holding off at random by the sender's idle percentage.
   always @(posedge clock) begin : request_driver
      pst_pkg::item_type next_req;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_req = request_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_req.tick;
            req_tdata  <= {next_req.reserve_mv, next_req.main_mv};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response monitor: checks each response against the oldest expectation,
   // then predicts the response owed for a request accepted at this edge and
   // tracks configuration writes, all from values sampled before the edge.
   always @(posedge clock) begin : response_monitor
      pst_pkg::result_type want;
      if (reset) begin
         rsp_tready          <= 1'b0;
         cfg_threshold_mv    = pst_pkg::THRESHOLD_RST;
         cfg_violation_limit = pst_pkg::VIOL_LIMIT_RST;
         cfg_dead_time       = pst_pkg::DEAD_TIME_RST;
         // Out of reset a switch to no source is already under way.
         sw_active       = pst_pkg::SRC_NONE;
         sw_target       = pst_pkg::SRC_NONE;
         sw_in_dead      = 1'b1;
         sw_viol         = '0;
         sw_dead_cnt     = '0;
         sw_gates        = pst_pkg::GATES_OFF;
         sw_last_main    = '0;
         sw_last_reserve = '0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (switch_expect_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Unexpected response 0x%0h with no request outstanding",
                           rsp_tdata);
               end
            end else begin
               want = switch_expect_q.pop_front();
               check_field("active_source", 16'(want.active_source), 16'(rsp_tdata[1:0]));
               check_field("target_source", 16'(want.target_source), 16'(rsp_tdata[3:2]));
               check_field("switching", 16'(want.switching), 16'(rsp_tdata[4]));
               check_field("gate_drive", 16'(want.gate_drive), 16'(rsp_tdata[8:5]));
               check_field("violations", 16'(want.violations), 16'(rsp_tdata[16:9]));
               check_field("active_voltage_mv", want.active_voltage_mv, rsp_tdata[32:17]);
               check_field("switch_started", 16'(want.switch_started), 16'(rsp_tdata[33]));
               check_field("padding", 16'd0, 16'(rsp_tdata[39:34]));
               responses_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            switch_expect_q.push_back(advance_switch(req_tuser[0], req_tdata[15:0],
                                                     req_tdata[31:16]));
            requests_seen++;
         end
         if (csr_we) begin
            case (csr_addr)
               pst_pkg::CSR_THRESHOLD:  cfg_threshold_mv    = csr_wdata;
               pst_pkg::CSR_VIOL_LIMIT: cfg_violation_limit = csr_wdata[pst_pkg::VIOL_W-1:0];
               pst_pkg::CSR_DEAD_TIME:  cfg_dead_time       = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses outstanding",
                  cycle_count, switch_expect_q.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic queue_request(input logic tick, input logic [pst_pkg::MV_W-1:0] main_mv,
                                input logic [pst_pkg::MV_W-1:0] reserve_mv);
      pst_pkg::item_type it;
      it.tick       = tick;
      it.main_mv    = main_mv;
      it.reserve_mv = reserve_mv;
      request_q.push_back(it);
   endtask

   // Ticks carry random don't-care data so that every data bit toggles.
   task automatic queue_ticks(input int unsigned count);
      repeat (count) begin
         queue_request(1'b1, 16'($urandom), 16'($urandom));
      end
   endtask

   // Register writes happen only with nothing in flight; the trailing
   // negedge lets the monitor pick up the new value before stimulus is built.
   task automatic write_csr(input logic [pst_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [pst_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Holds the sender until every queued request is answered. The response
   // path runs through the input register and the response register.
   task automatic wait_settled();
      do begin
         @(negedge clock);
      end while (request_q.size() != 0 || req_tvalid || switch_expect_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic start_phase(input logic [pst_pkg::MV_W-1:0] threshold,
                              input logic [pst_pkg::VIOL_W-1:0] limit,
                              input logic [pst_pkg::TICK_W-1:0] dead_time,
                              input int unsigned send_idle, input int unsigned recv_stall);
      wait_settled();
      write_csr(pst_pkg::CSR_THRESHOLD, threshold);
      write_csr(pst_pkg::CSR_VIOL_LIMIT, 16'(limit));
      write_csr(pst_pkg::CSR_DEAD_TIME, dead_time);
      send_idle_pct  = send_idle;
      recv_stall_pct = recv_stall;
   endtask

   // A voltage on the requested side of the threshold, biased to the edges.
   // With a zero threshold nothing can be bad, so any value is returned.
   function automatic logic [pst_pkg::MV_W-1:0] pick_mv(input logic good);
      int unsigned thr;
      thr = cfg_threshold_mv;
      if (good || thr == 0) begin
         case ($urandom_range(2))
            0:       return 16'(thr);
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(65535, thr));
         endcase
      end
      case ($urandom_range(2))
         0:       return 16'(thr - 1);
         1:       return 16'd0;
         default: return 16'($urandom_range(thr - 1, 0));
      endcase
   endfunction

   // Mostly runs of samples of one supply condition, long enough to reach the
   // violation limit, followed by enough ticks to finish any switch. The rest
   // is fully random noise, short runs and stray tick bursts.
   task automatic run_random(input int unsigned count);
      int unsigned made;
      int unsigned kind;
      int unsigned len;
      int unsigned base;
      int unsigned dead;
      logic        main_good;
      logic        res_good;
      made = 0;
      dead = cfg_dead_time;
      while (made < count) begin
         kind = $urandom_range(99);
         if (kind < 15) begin
            queue_request(1'($urandom_range(1)), 16'($urandom), 16'($urandom));
            made++;
         end else if (kind < 25) begin
            len = dead + $urandom_range(2);
            if (len == 0) begin
               len = 1;
            end
            queue_ticks(len);
            made += len;
         end else begin
            base = (cfg_violation_limit == 0) ? 1 : cfg_violation_limit;
            len  = ($urandom_range(3) == 0) ? $urandom_range(base, 1)
                                            : base + $urandom_range(2);
            {main_good, res_good} = 2'($urandom_range(3));
            repeat (len) begin
               if ($urandom_range(15) == 0) begin
                  queue_request(1'b0, pick_mv(1'($urandom_range(1))),
                                pick_mv(1'($urandom_range(1))));
               end else begin
                  queue_request(1'b0, pick_mv(main_good), pick_mv(res_good));
               end
            end
            queue_ticks(dead + 1);
            made += len + dead + 1;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The undecoded index must leave the reset configuration alone.
      write_csr(CSR_UNUSED, 16'hFFFF);

      // Reset leaves a switch to no source pending: samples are ignored and
      // ticks run the dead-time counter against the reset dead time.
      queue_request(1'b0, 16'hFFFF, 16'hFFFF);
      queue_request(1'b0, 16'h0000, 16'h0000);
      queue_ticks(3);
      start_phase(pst_pkg::THRESHOLD_RST, pst_pkg::VIOL_LIMIT_RST, 16'd2, 0, 0);

      // Directed walk through every transition at the reset threshold.
      queue_ticks(1);                              // counter already past the dead time
      repeat (3) queue_request(1'b0, 16'hFFFF, 16'h0000);  // none toward main
      queue_request(1'b0, 16'h0000, 16'h0000);     // dropped during the dead time
      queue_ticks(2);
      queue_request(1'b0, 16'd10000, 16'd0);       // main exactly at the threshold
      repeat (3) queue_request(1'b0, 16'd9999, 16'hFFFF);  // main to reserve
      queue_ticks(2);
      repeat (2) queue_request(1'b0, 16'hFFFF, 16'hFFFF);  // main back, counting
      queue_request(1'b0, 16'd0, 16'd10000);       // reserve fine, count clears
      repeat (3) queue_request(1'b0, 16'd0, 16'd0);        // both bad to none
      queue_ticks(2);
      repeat (3) queue_request(1'b0, 16'd1, 16'd9999);     // none to none again
      queue_ticks(3);                              // last one is an idle tick

      // Long dead time: one violation opens a switch, then the counter
      // must climb all the way to the dead time before the switch completes.
      start_phase(pst_pkg::THRESHOLD_RST, 8'd1, 16'd150, 0, 0);
      queue_request(1'b0, 16'd0, 16'd0);
      queue_ticks(152);

      // Random phases across threshold, limit and dead-time extremes.
      start_phase(pst_pkg::THRESHOLD_RST, pst_pkg::VIOL_LIMIT_RST, 16'd4, 0, 0);
      run_random(180);
      start_phase(16'd0, 8'd1, 16'd0, 59, 0);
      run_random(110);
      start_phase(16'hFFFF, 8'd2, 16'd7, 0, 59);
      run_random(110);
      start_phase(16'd40000, 8'd0, 16'd1, 27, 27);
      run_random(110);
      start_phase(16'd1, 8'hFF, 16'd2, 0, 0);
      run_random(220);
      start_phase(16'($urandom_range(65535)), 8'($urandom_range(8, 1)),
                  16'($urandom_range(10)), 27, 27);
      run_random(70);
      // Sender holds back until the switch has answered everything so far.
      wait_settled();
      run_random(70);

      wait_settled();
      repeat (10) @(negedge clock);
      if (switch_expect_q.size() != 0) begin
         mismatches += switch_expect_q.size();
         $display("%0d responses never arrived", switch_expect_q.size());
      end

      $display("Checked %0d responses to %0d requests; %0d switches started, %0d completed.",
               responses_checked, requests_seen, switches_started, switches_done);
      $display("Thresholds 0 to 65535, limits 0 to 255, dead times 0 to 150, %0d mismatches.",
               mismatches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
